@@ hdl/bhmh_pkg.sv @@
// Package for the byte histogram / min-heap block: defaults, widths,
// command codes and controller states. Used by every file but bhmh_ram.
`default_nettype none
package bhmh_pkg;

    localparam int SYMBOLS_DEF    = 256;
    localparam int COUNT_BITS_DEF = 32;
    localparam int SYM_W          = 8;
    localparam int MODE_W         = 2;
    localparam int OUT_CNT_W      = 32;
    localparam int REM_W          = 9;
    localparam int OUT_DATA_W     = 56;

    typedef enum logic [MODE_W-1:0] {
        MODE_COUNT = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_POP   = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_WR,
        ST_LOAD,
        ST_DRAIN,
        ST_HFY_RD,
        ST_HFY_LD,
        ST_POP_RD0,
        ST_POP_RDL,
        ST_POP_LD,
        ST_POP_OUT,
        ST_SFT_RL,
        ST_SFT_RR,
        ST_SFT_CMP
    } state_t;

endpackage
`default_nettype wire

@@ hdl/bhmh_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bhmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ hdl/byte_histogram_min_heap.sv @@
// Top level of the byte histogram and min-heap front end.
// Depends on bhmh_pkg and bhmh_ram.
//
//  channel  | signals                          | contents (lowest bit first)
//  ---------+----------------------------------+--------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser| tdata: symbol[7:0]; tuser: mode[1:0]
//  output   | m_tvalid m_tready m_tdata m_tuser| tdata: out_symbol, out_count,
//           |                                  | remaining, zero fill; tuser: heap_empty
//
// A count reads the histogram RAM, then writes back a saturating increment.
// A build scans the histogram into the heap RAM, then, for each of the
// n/2+1 heapify roots, loads the root and sifts it down until it settles.
// A pop reads the root and the last entry, outputs the root, then sifts the
// last entry down from the root until it settles; an empty pop only outputs.
// After reset the histogram is cleared one entry a cycle with s_tready low.
// A stalled result is held in the output register; the block only waits
// there if a new pop result is ready before the old one is taken.
`default_nettype none
module byte_histogram_min_heap #(
    parameter int SYMBOLS    = bhmh_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS = bhmh_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bhmh_pkg::SYM_W-1:0]      s_tdata,   // symbol
    input  wire logic [bhmh_pkg::MODE_W-1:0]     s_tuser,   // mode
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bhmh_pkg::OUT_DATA_W-1:0]      m_tdata,   // out_symbol, out_count,
                                                            // remaining, zeros
    output logic [0:0]                           m_tuser    // heap_empty
);

    localparam int HA_W  = $clog2(SYMBOLS);
    localparam int CNT_W = $clog2(SYMBOLS + 1);
    localparam int CX_W  = HA_W + 2;
    localparam int ENT_W = COUNT_BITS + bhmh_pkg::SYM_W;
    localparam int SW    = bhmh_pkg::SYM_W;

    bhmh_pkg::state_t state_reg, state_next;

    // histogram RAM
    logic                  h_we;
    logic [HA_W-1:0]       h_waddr, h_raddr;
    logic [COUNT_BITS-1:0] h_wdata, h_rdata;

    // heap RAM, entry = {count, symbol}
    logic             p_we;
    logic [HA_W-1:0]  p_waddr, p_raddr;
    logic [ENT_W-1:0] p_wdata, p_rdata;

    logic [HA_W-1:0]       clr_reg;
    logic [HA_W-1:0]       cnt_addr_reg;
    logic [8:0]            k_reg;
    logic                  ld_v_reg;
    logic [SW-1:0]         ld_sym_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [HA_W-1:0]       i_reg;
    logic [HA_W-1:0]       pos_reg;
    logic                  bld_reg;
    logic                  pop_empty_reg;
    logic [SW-1:0]         cur_sym_reg;
    logic [COUNT_BITS-1:0] cur_cnt_reg;
    logic [SW-1:0]         l_sym_reg;
    logic [COUNT_BITS-1:0] l_cnt_reg;
    logic [SW-1:0]         res_sym_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;
    logic [CNT_W-1:0]      res_rem_reg;

    logic                               m_tvalid_reg;
    logic [bhmh_pkg::OUT_DATA_W-1:0]    m_tdata_reg;
    logic                               m_tuser_reg;

    logic            accept;
    logic            sym_ok;
    logic [SW-1:0]   scan_sym;
    logic            scan_ok;
    logic            ld_hit;
    logic [CNT_W-1:0] n_after_ld;
    logic [CX_W-1:0] l_idx, r_idx, n_ext;
    logic            l_ok, r_ok;
    logic            l_lt, r_lt;
    logic [COUNT_BITS-1:0] min_cnt;
    logic            swap;
    logic            out_free;
    logic            fin;
    logic [63:0]     res_cnt_wide;

    assign accept   = s_tvalid && s_tready;
    assign sym_ok   = {1'b0, s_tdata} < 9'(SYMBOLS);
    // ascending signed-byte order: 128..255 then 0..127
    assign scan_sym = {~k_reg[7], k_reg[6:0]};
    assign scan_ok  = {1'b0, scan_sym} < 9'(SYMBOLS);
    assign ld_hit   = ld_v_reg && (h_rdata != '0);
    assign n_after_ld = ld_hit ? n_reg + CNT_W'(1) : n_reg;

    assign l_idx = CX_W'({pos_reg, 1'b1});
    assign r_idx = CX_W'({pos_reg, 1'b1}) + CX_W'(1);
    assign n_ext = CX_W'(n_reg);
    assign l_ok  = l_idx < n_ext;
    assign r_ok  = r_idx < n_ext;

    // sift-down choice: left wins only if strictly smaller, right only if
    // strictly smaller than the current minimum
    assign l_lt    = l_cnt_reg < cur_cnt_reg;
    assign min_cnt = l_lt ? l_cnt_reg : cur_cnt_reg;
    assign r_lt    = r_ok && (p_rdata[ENT_W-1:SW] < min_cnt);
    assign swap    = l_lt || r_lt;

    assign out_free = !m_tvalid_reg || m_tready;
    // sift ends: moving entry settles at pos
    assign fin = (state_reg == bhmh_pkg::ST_SFT_RL && !l_ok) ||
                 (state_reg == bhmh_pkg::ST_SFT_CMP && !swap);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bhmh_pkg::ST_CLEAR:
            begin
                if (clr_reg == HA_W'(SYMBOLS - 1))
                begin
                    state_next = bhmh_pkg::ST_IDLE;
                end
            end
            bhmh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        bhmh_pkg::MODE_COUNT:
                            state_next = sym_ok ? bhmh_pkg::ST_CNT_WR : bhmh_pkg::ST_IDLE;
                        bhmh_pkg::MODE_BUILD:
                            state_next = bhmh_pkg::ST_LOAD;
                        bhmh_pkg::MODE_POP:
                            state_next = (n_reg == '0) ? bhmh_pkg::ST_POP_OUT
                                                       : bhmh_pkg::ST_POP_RD0;
                        default:
                            state_next = bhmh_pkg::ST_IDLE;
                    endcase
                end
            end
            bhmh_pkg::ST_CNT_WR:  state_next = bhmh_pkg::ST_IDLE;
            bhmh_pkg::ST_LOAD:
            begin
                if (k_reg == 9'd255)
                begin
                    state_next = bhmh_pkg::ST_DRAIN;
                end
            end
            bhmh_pkg::ST_DRAIN:   state_next = bhmh_pkg::ST_HFY_RD;
            bhmh_pkg::ST_HFY_RD:
                state_next = (n_reg == '0) ? bhmh_pkg::ST_IDLE : bhmh_pkg::ST_HFY_LD;
            bhmh_pkg::ST_HFY_LD:  state_next = bhmh_pkg::ST_SFT_RL;
            bhmh_pkg::ST_POP_RD0: state_next = bhmh_pkg::ST_POP_RDL;
            bhmh_pkg::ST_POP_RDL: state_next = bhmh_pkg::ST_POP_LD;
            bhmh_pkg::ST_POP_LD:  state_next = bhmh_pkg::ST_POP_OUT;
            bhmh_pkg::ST_POP_OUT:
            begin
                if (out_free)
                begin
                    state_next = pop_empty_reg ? bhmh_pkg::ST_IDLE : bhmh_pkg::ST_SFT_RL;
                end
            end
            bhmh_pkg::ST_SFT_RL,
            bhmh_pkg::ST_SFT_CMP:
            begin
                if (fin)
                begin
                    state_next = (bld_reg && i_reg != '0) ? bhmh_pkg::ST_HFY_RD
                                                          : bhmh_pkg::ST_IDLE;
                end
                else if (state_reg == bhmh_pkg::ST_SFT_RL)
                begin
                    state_next = bhmh_pkg::ST_SFT_RR;
                end
                else
                begin
                    state_next = bhmh_pkg::ST_SFT_RL;
                end
            end
            bhmh_pkg::ST_SFT_RR:  state_next = bhmh_pkg::ST_SFT_CMP;
            default:              state_next = bhmh_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        s_tready = (state_reg == bhmh_pkg::ST_IDLE);
        h_we     = 1'b0;
        h_waddr  = cnt_addr_reg;
        h_wdata  = (h_rdata == '1) ? h_rdata : h_rdata + COUNT_BITS'(1);
        h_raddr  = s_tdata[HA_W-1:0];
        p_we     = 1'b0;
        p_waddr  = pos_reg;
        p_wdata  = {cur_cnt_reg, cur_sym_reg};
        p_raddr  = i_reg;
        case (state_reg)
            bhmh_pkg::ST_CLEAR:
            begin
                h_we    = 1'b1;
                h_waddr = clr_reg;
                h_wdata = '0;
            end
            bhmh_pkg::ST_CNT_WR:
            begin
                h_we = 1'b1;
            end
            bhmh_pkg::ST_LOAD,
            bhmh_pkg::ST_DRAIN:
            begin
                h_raddr = scan_sym[HA_W-1:0];
                p_we    = ld_hit;
                p_waddr = n_reg[HA_W-1:0];
                p_wdata = {h_rdata, ld_sym_reg};
            end
            bhmh_pkg::ST_POP_RD0:
            begin
                p_raddr = '0;
            end
            bhmh_pkg::ST_POP_RDL:
            begin
                p_raddr = HA_W'(n_reg - CNT_W'(1));
            end
            bhmh_pkg::ST_SFT_RL:
            begin
                p_raddr = l_idx[HA_W-1:0];
                p_we    = !l_ok;
            end
            bhmh_pkg::ST_SFT_RR:
            begin
                p_raddr = r_idx[HA_W-1:0];
            end
            bhmh_pkg::ST_SFT_CMP:
            begin
                p_we = 1'b1;
                if (r_lt)
                begin
                    p_wdata = p_rdata;
                end
                else if (l_lt)
                begin
                    p_wdata = {l_cnt_reg, l_sym_reg};
                end
            end
            default:
            begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bhmh_pkg::ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            ld_v_reg      <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            pos_reg       <= '0;
            bld_reg       <= 1'b0;
            pop_empty_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                bhmh_pkg::ST_CLEAR:
                begin
                    clr_reg <= clr_reg + HA_W'(1);
                end
                bhmh_pkg::ST_IDLE:
                begin
                    k_reg    <= '0;
                    ld_v_reg <= 1'b0;
                    if (accept && s_tuser == bhmh_pkg::MODE_BUILD)
                    begin
                        bld_reg <= 1'b1;
                        n_reg   <= '0;
                    end
                    if (accept && s_tuser == bhmh_pkg::MODE_POP)
                    begin
                        bld_reg       <= 1'b0;
                        pop_empty_reg <= (n_reg == '0);
                    end
                end
                bhmh_pkg::ST_LOAD:
                begin
                    k_reg    <= k_reg + 9'd1;
                    ld_v_reg <= scan_ok;
                    n_reg    <= n_after_ld;
                end
                bhmh_pkg::ST_DRAIN:
                begin
                    ld_v_reg <= 1'b0;
                    n_reg    <= n_after_ld;
                    i_reg    <= HA_W'(n_after_ld >> 1);
                end
                bhmh_pkg::ST_HFY_LD:
                begin
                    pos_reg <= i_reg;
                end
                bhmh_pkg::ST_POP_LD:
                begin
                    n_reg   <= n_reg - CNT_W'(1);
                    pos_reg <= '0;
                end
                bhmh_pkg::ST_POP_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                bhmh_pkg::ST_SFT_CMP:
                begin
                    if (swap)
                    begin
                        pos_reg <= r_lt ? r_idx[HA_W-1:0] : l_idx[HA_W-1:0];
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
            if (fin && bld_reg && i_reg != '0)
            begin
                i_reg <= i_reg - HA_W'(1);
            end
        end
    end

    // payload registers
    assign res_cnt_wide = 64'(res_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_addr_reg <= s_tdata[HA_W-1:0];
            res_sym_reg  <= '0;
            res_cnt_reg  <= '0;
            res_rem_reg  <= '0;
        end
        if (state_reg == bhmh_pkg::ST_LOAD)
        begin
            ld_sym_reg <= scan_sym;
        end
        if (state_reg == bhmh_pkg::ST_HFY_LD || state_reg == bhmh_pkg::ST_POP_LD)
        begin
            cur_sym_reg <= p_rdata[SW-1:0];
            cur_cnt_reg <= p_rdata[ENT_W-1:SW];
        end
        if (state_reg == bhmh_pkg::ST_POP_LD)
        begin
            res_rem_reg <= n_reg - CNT_W'(1);
        end
        if (state_reg == bhmh_pkg::ST_POP_RDL)
        begin
            res_sym_reg <= p_rdata[SW-1:0];
            res_cnt_reg <= p_rdata[ENT_W-1:SW];
        end
        if (state_reg == bhmh_pkg::ST_SFT_RR)
        begin
            l_sym_reg <= p_rdata[SW-1:0];
            l_cnt_reg <= p_rdata[ENT_W-1:SW];
        end
        if (state_reg == bhmh_pkg::ST_POP_OUT && out_free)
        begin
            m_tdata_reg <= {7'd0, bhmh_pkg::REM_W'(res_rem_reg), res_cnt_wide[31:0],
                            res_sym_reg};
            m_tuser_reg <= pop_empty_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    bhmh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SYMBOLS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (h_we),
        .wr_addr (h_waddr),
        .wr_data (h_wdata),
        .rd_addr (h_raddr),
        .rd_data (h_rdata)
    );

    bhmh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOLS)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (p_waddr),
        .wr_data (p_wdata),
        .rd_addr (p_raddr),
        .rd_data (p_rdata)
    );

endmodule
`default_nettype wire

@@ hdl/bhmh_checker.sv @@
// Port-level checks for byte_histogram_min_heap, bound to the top level.
// Depends on bhmh_pkg.
`default_nettype none
module bhmh_checker #(
    parameter int SYMBOLS = bhmh_pkg::SYMBOLS_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [bhmh_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [0:0]                      m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // empty pop carries all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("empty pop with nonzero fields");

    // remaining count after a pop is always below SYMBOLS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[48:40] < 9'(SYMBOLS))
        else $error("remaining out of range");

    // no result can appear the cycle after a transfer in
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

endmodule

bind byte_histogram_min_heap bhmh_checker #(.SYMBOLS(SYMBOLS)) u_bhmh_checker (.*);
`default_nettype wire

@@ dv/byte_histogram_min_heap_test.sv @@
// Self-checking bench for byte_histogram_min_heap: count, build and pop
// transfers with a behavioural histogram/heap predictor. Depends on bhmh_pkg.
`timescale 1ns / 100ps
`default_nettype none
module byte_histogram_min_heap_test;

    localparam logic [1:0] MODE_NONE = 2'd3;   // unused mode code
    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [31:0] count;
        logic        empty;
        logic [8:0]  left;
    } pop_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [bhmh_pkg::SYM_W-1:0] s_tdata = '0;
    logic [bhmh_pkg::MODE_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [bhmh_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    byte_histogram_min_heap u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state
    logic [31:0] freq [256];
    logic [7:0]  hp_sym [256];
    logic [31:0] hp_cnt [256];
    int          hp_n;

    cmd_t pending_cmds [$];
    pop_t expected_pops [$];
    int   mismatches = 0;
    int   pops_seen = 0;
    int   builds_sent = 0;
    longint cycles = 0;
    bit   quiet = 1'b0;      // stretch with no idling
    bit   stim_done = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void swap_entries(int a, int b);
        logic [7:0]  ts;
        logic [31:0] tc;
        ts = hp_sym[a]; tc = hp_cnt[a];
        hp_sym[a] = hp_sym[b]; hp_cnt[a] = hp_cnt[b];
        hp_sym[b] = ts; hp_cnt[b] = tc;
    endfunction

    function automatic void sink(int pos);
        int l, r, m;
        forever
        begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            m = pos;
            if (l < hp_n && hp_cnt[l] < hp_cnt[pos]) m = l;
            if (r < hp_n && hp_cnt[r] < hp_cnt[m]) m = r;
            if (m == pos) return;
            swap_entries(m, pos);
            pos = m;
        end
    endfunction

    // Advance the model by one accepted command; queue a pop result if any.
    function automatic void apply_cmd(cmd_t c);
        pop_t p;
        int s;
        case (c.mode)
            bhmh_pkg::MODE_COUNT:
                if (freq[c.symbol] != 32'hFFFF_FFFF) freq[c.symbol]++;
            bhmh_pkg::MODE_BUILD:
            begin
                hp_n = 0;
                for (int k = 0; k < 256; k++)
                begin
                    s = (k + 128) & 8'hFF;
                    if (freq[s] != 0)
                    begin
                        hp_sym[hp_n] = s[7:0];
                        hp_cnt[hp_n] = freq[s];
                        hp_n++;
                    end
                end
                if (hp_n > 0)
                    for (int i = hp_n / 2; i >= 0; i--) sink(i);
            end
            bhmh_pkg::MODE_POP:
            begin
                p = '0;
                if (hp_n == 0)
                    p.empty = 1'b1;
                else
                begin
                    p.symbol = hp_sym[0];
                    p.count = hp_cnt[0];
                    hp_sym[0] = hp_sym[hp_n - 1];
                    hp_cnt[0] = hp_cnt[hp_n - 1];
                    hp_n--;
                    sink(0);
                    p.left = hp_n[8:0];
                end
                expected_pops.push_back(p);
            end
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(logic [1:0] mode, logic [7:0] symbol);
        cmd_t c;
        c.mode = mode;
        c.symbol = symbol;
        pending_cmds.push_back(c);
        if (mode == bhmh_pkg::MODE_BUILD) builds_sent++;
    endfunction

    // Fill the stimulus queue: directed part, then random count/build/pop rounds.
    initial
    begin
        int n_count, n_pop, hot;
        for (int i = 0; i < 256; i++) freq[i] = '0;
        hp_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pop, build on empty histogram, unused mode
        add_cmd(bhmh_pkg::MODE_POP, 8'h00);
        add_cmd(bhmh_pkg::MODE_BUILD, 8'hFF);
        add_cmd(bhmh_pkg::MODE_POP, 8'h55);
        add_cmd(MODE_NONE, 8'hAA);
        // Extremes of symbol, ties, signed order
        add_cmd(bhmh_pkg::MODE_COUNT, 8'h00);
        add_cmd(bhmh_pkg::MODE_COUNT, 8'hFF);
        add_cmd(bhmh_pkg::MODE_COUNT, 8'h80);
        add_cmd(bhmh_pkg::MODE_COUNT, 8'h7F);
        add_cmd(bhmh_pkg::MODE_COUNT, 8'h7F);
        add_cmd(bhmh_pkg::MODE_COUNT, 8'h01);
        add_cmd(bhmh_pkg::MODE_BUILD, 8'h00);
        add_cmd(bhmh_pkg::MODE_POP, 8'h00);
        add_cmd(bhmh_pkg::MODE_COUNT, 8'h01);   // count after build: heap unchanged
        add_cmd(bhmh_pkg::MODE_POP, 8'h00);
        add_cmd(bhmh_pkg::MODE_BUILD, 8'h00);   // rebuild
        for (int i = 0; i < 7; i++) add_cmd(bhmh_pkg::MODE_POP, 8'h00);

        // Random rounds: counts skewed to a few hot symbols, then a build and a run of pops
        while (pending_cmds.size() < 1600)
        begin
            n_count = $urandom_range(1, 60);
            hot = $urandom_range(0, 255);
            for (int i = 0; i < n_count; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    add_cmd($urandom_range(0, 1) ? MODE_NONE : bhmh_pkg::MODE_POP,
                            8'($urandom));
                else if ($urandom_range(0, 2) == 0)
                    add_cmd(bhmh_pkg::MODE_COUNT, 8'(hot[7:0] ^ $urandom_range(0, 7)));
                else
                    add_cmd(bhmh_pkg::MODE_COUNT, 8'($urandom));
            end
            add_cmd(bhmh_pkg::MODE_BUILD, 8'($urandom));
            n_pop = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            for (int i = 0; i < n_pop; i++) add_cmd(bhmh_pkg::MODE_POP, 8'($urandom));
        end
        stim_done = 1'b1;
    end

    // Driver: present the head of the queue, drop it on transfer.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 4000 == 1000) quiet <= ~quiet;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_cmd(pending_cmds.pop_front());
            end
            // the queue head is now the next item to present
            if ((!s_tvalid || s_tready) && pending_cmds.size() > 0)
            begin
                if (quiet || $urandom_range(0, 99) >= 8)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_cmds[0].symbol;
                    s_tuser <= pending_cmds[0].mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (s_tvalid && s_tready)
                s_tvalid <= 1'b0;
            m_tready <= quiet || $urandom_range(0, 99) >= 8;
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        pop_t exp_p;
        pop_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.symbol = m_tdata[7:0];
            got.count = m_tdata[39:8];
            got.left = m_tdata[48:40];
            got.empty = m_tuser[0];
            pops_seen++;
            if (expected_pops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sym %0d cnt %0d empty %0d rem %0d",
                             got.symbol, got.count, got.empty, got.left);
            end
            else
            begin
                exp_p = expected_pops.pop_front();
                if (got !== exp_p)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pop mismatch: exp sym %0d cnt %0d empty %0d rem %0d,",
                                  " got sym %0d cnt %0d empty %0d rem %0d"},
                                 exp_p.symbol, exp_p.count, exp_p.empty, exp_p.left,
                                 got.symbol, got.count, got.empty, got.left);
                end
            end
        end
    end

    // End of run: drain, settle, report.
    initial
    begin
        wait (stim_done && pending_cmds.size() == 0 && expected_pops.size() == 0);
        repeat (3000) @(posedge clk);
        $display("Ran %0d builds and checked %0d pop results.", builds_sent, pops_seen);
        if (mismatches == 0 && expected_pops.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        wait (cycles >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hdl/bhmh_pkg.sv
hdl/bhmh_ram.sv
hdl/byte_histogram_min_heap.sv
hdl/bhmh_checker.sv
dv/byte_histogram_min_heap_test.sv
